@@ src/frvad_pkg.sv @@
package frvad_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SQUARE_W   = 32;
  localparam int unsigned SUM_W      = 41;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned MAX_FRAME  = 1024;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned RMS_W      = 16;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned HOLD_W     = 8;
  localparam int unsigned FS_W       = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // shared serial divider: dividend width and step count
  localparam int unsigned DIV_W      = SUM_W;
  localparam int unsigned DIV_STEPS  = DIV_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int unsigned DVSR_W     = 16;

  // square root: two radicand bits per step
  localparam int unsigned SQRT_IN_W  = 32;
  localparam int unsigned SQRT_STEPS = SQRT_IN_W / 2;
  localparam int unsigned SQRT_CNT_W = $clog2(SQRT_STEPS);
  localparam int unsigned SQRT_REM_W = RMS_W + 1;

  localparam logic [THR_W-1:0]  THRESHOLD_RST  = 16'd500;
  localparam logic [HOLD_W-1:0] HOLD_RST       = 8'd15;
  localparam logic [FS_W-1:0]   FULL_SCALE_RST = 16'd5000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE     = 3'd0,
    REG_MUTED      = 3'd1,
    REG_THRESHOLD  = 3'd2,
    REG_HOLD       = 3'd3,
    REG_FULL_SCALE = 3'd4
  } frvad_reg_e;

  typedef enum logic {
    JOB_DROP  = 1'b0,
    JOB_FRAME = 1'b1
  } frvad_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_SQRT,
    ST_LSTART,
    ST_LEVEL,
    ST_DONE
  } frvad_state_e;

  typedef struct packed {
    frvad_kind_e      kind;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } frvad_job_t;

  typedef struct packed {
    logic              enable;
    logic              muted;
    logic [THR_W-1:0]  threshold;
    logic [HOLD_W-1:0] hold;
    logic [FS_W-1:0]   full_scale;
  } frvad_cfg_t;

endpackage

@@ src/frame_rms_voice_activity_detector_top.sv @@
// back end: a frame result follows its closing sample through a 41-step mean divide,
//   a 16-step root and a 41-step level divide
// throughput: one sample per cycle while the two-entry job queue has room; the back end
//   ends one job before it takes the next, with the shared serial divider and root unit
// reset: asynchronous active low; registers load 0, 0, 500, 15, 5000 and the
//   accumulator, speaking state and silence count clear
module frame_rms_voice_activity_detector_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // sample channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [frvad_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                  frame_end_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [frvad_pkg::LEVEL_W-1:0]         level_o,
  output logic [frvad_pkg::RMS_W-1:0]           rms_value_o,
  output logic                                  speaking_o,
  output logic                                  speaking_changed_o,
  output logic                                  transmit_frame_o,
  // register write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [frvad_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [frvad_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import frvad_pkg::*;

  frvad_cfg_t cfg_q;
  logic       push, full, pop, empty;
  frvad_job_t job_in, job_out;

  // registers always accept a write
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable     <= 1'b0;
      cfg_q.muted      <= 1'b0;
      cfg_q.threshold  <= THRESHOLD_RST;
      cfg_q.hold       <= HOLD_RST;
      cfg_q.full_scale <= FULL_SCALE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_ENABLE:     cfg_q.enable     <= cfg_data_i[0];
        REG_MUTED:      cfg_q.muted      <= cfg_data_i[0];
        REG_THRESHOLD:  cfg_q.threshold  <= cfg_data_i[THR_W-1:0];
        REG_HOLD:       cfg_q.hold       <= cfg_data_i[HOLD_W-1:0];
        REG_FULL_SCALE: cfg_q.full_scale <= cfg_data_i[FS_W-1:0];
        default: ;  // unmapped index, write ignored
      endcase
    end
  end

  // front end: squares and sums samples, posts one job per frame end
  // and one per sample dropped while disabled
  frvad_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enable_i    (cfg_q.enable),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .frame_end_i (frame_end_i),
    .push_o      (push),
    .job_o       (job_in),
    .full_i      (full)
  );

  // short job queue lets the front keep taking samples while the back works
  frvad_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (job_out)
  );

  // back end: mean, root, level scaling, voice rule and output register
  frvad_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .empty_i            (empty),
    .job_i              (job_out),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .level_o            (level_o),
    .rms_value_o        (rms_value_o),
    .speaking_o         (speaking_o),
    .speaking_changed_o (speaking_changed_o),
    .transmit_frame_o   (transmit_frame_o)
  );

endmodule

@@ src/frvad_fifo.sv @@
module frvad_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  frvad_pkg::frvad_job_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output frvad_pkg::frvad_job_t data_o
);
  import frvad_pkg::*;

  frvad_job_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;

  assign full_o  = fill_q[1];
  assign empty_o = (fill_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

@@ src/frvad_div.sv @@
module frvad_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [frvad_pkg::DIV_W-1:0]  dividend_i,
  input  logic [frvad_pkg::DVSR_W-1:0] divisor_i,
  output logic                          done_o,
  output logic [frvad_pkg::DIV_W-1:0]  quotient_o
);
  import frvad_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     quo_q;
  logic [DVSR_W-1:0]    rem_q;
  logic [DVSR_W-1:0]    dvsr_q;
  logic [DVSR_W:0]      trial;
  logic                 fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvsr_q});

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= dividend_i;
      rem_q  <= '0;
      dvsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], fits};
      rem_q <= fits ? DVSR_W'(trial - {1'b0, dvsr_q}) : trial[DVSR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

endmodule

@@ src/frvad_front.sv @@
module frvad_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           enable_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [frvad_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                           frame_end_i,
  output logic                           push_o,
  output frvad_pkg::frvad_job_t          job_o,
  input  logic                           full_i
);
  import frvad_pkg::*;

  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                accept;
  logic [SAMPLE_W-1:0] mag;
  logic [SQUARE_W-1:0] square;
  logic                room;
  logic [SUM_W-1:0]    sum_new;
  logic [CNT_W-1:0]    cnt_new;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // magnitude of -32768 wraps to 0x8000, which is its true magnitude
  assign mag    = sample_i[SAMPLE_W-1] ? SAMPLE_W'(-sample_i) : SAMPLE_W'(sample_i);
  assign square = SQUARE_W'(mag) * SQUARE_W'(mag);
  assign room   = (cnt_q < CNT_W'(MAX_FRAME));

  assign sum_new = room ? sum_q + SUM_W'(square) : sum_q;
  assign cnt_new = room ? cnt_q + CNT_W'(1) : cnt_q;

  always_comb begin
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    push_o     = 1'b0;
    job_o.kind  = JOB_FRAME;
    job_o.sum   = sum_new;
    job_o.count = cnt_new;
    if (accept) begin
      if (!enable_i) begin
        sum_d      = '0;
        cnt_d      = '0;
        push_o     = 1'b1;
        job_o.kind = JOB_DROP;
      end else if (frame_end_i) begin
        sum_d  = '0;
        cnt_d  = '0;
        push_o = 1'b1;
      end else begin
        sum_d = sum_new;
        cnt_d = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ src/frvad_back.sv @@
module frvad_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  frvad_pkg::frvad_cfg_t           cfg_i,
  input  logic                            empty_i,
  input  frvad_pkg::frvad_job_t           job_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [frvad_pkg::LEVEL_W-1:0]   level_o,
  output logic [frvad_pkg::RMS_W-1:0]     rms_value_o,
  output logic                            speaking_o,
  output logic                            speaking_changed_o,
  output logic                            transmit_frame_o
);
  import frvad_pkg::*;

  frvad_state_e          state_q, state_d;
  logic [SQRT_CNT_W-1:0] step_q, step_d;
  logic [SQRT_IN_W-1:0]  val_q, val_d;
  logic [SQRT_REM_W-1:0] rem_q, rem_d;
  logic [RMS_W-1:0]      root_q, root_d;
  logic [RMS_W-1:0]      rms_q, rms_d;
  logic [LEVEL_W-1:0]    lvl_q, lvl_d;
  logic                  spk_q, spk_d;
  logic [HOLD_W-1:0]     sil_q, sil_d;

  logic                  ov_q, ov_d;
  logic [LEVEL_W-1:0]    o_level_q, o_level_d;
  logic [RMS_W-1:0]      o_rms_q, o_rms_d;
  logic                  o_spk_q, o_spk_d;
  logic                  o_chg_q, o_chg_d;
  logic                  o_tx_q, o_tx_d;

  logic                  div_start, div_done;
  logic [DIV_W-1:0]      div_dividend, div_quotient;
  logic [DVSR_W-1:0]     div_divisor;

  logic [SQRT_REM_W+1:0] sq_shift, sq_trial;
  logic                  sq_fits;
  logic [SQUARE_W-1:0]   scaled;
  logic [FS_W-1:0]       fs_eff;
  logic                  out_free;
  logic                  v_spk;
  logic [HOLD_W-1:0]     v_sil, sil_inc;

  frvad_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  assign sq_shift = {rem_q, val_q[SQRT_IN_W-1 -: 2]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_fits  = (sq_shift >= sq_trial);

  // rms * 65535 as a shift and subtract
  assign scaled = {rms_q, 16'd0} - SQUARE_W'(rms_q);
  assign fs_eff = (cfg_i.full_scale == '0) ? FS_W'(1) : cfg_i.full_scale;

  assign out_free = ~ov_q | ~out_stall_i;
  assign sil_inc  = sil_q + HOLD_W'(1);

  always_comb begin
    v_spk = spk_q;
    v_sil = sil_q;
    if (rms_q >= cfg_i.threshold) begin
      v_sil = '0;
      if (!cfg_i.muted) v_spk = 1'b1;
    end else if (spk_q) begin
      v_sil = sil_inc;
      if (sil_inc >= cfg_i.hold) begin
        v_spk = 1'b0;
        v_sil = '0;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    val_d        = val_q;
    rem_d        = rem_q;
    root_d       = root_q;
    rms_d        = rms_q;
    lvl_d        = lvl_q;
    spk_d        = spk_q;
    sil_d        = sil_q;
    pop_o        = 1'b0;
    div_start    = 1'b0;
    div_dividend = DIV_W'(scaled);
    div_divisor  = fs_eff;
    ov_d         = ov_q & out_stall_i;
    o_level_d    = o_level_q;
    o_rms_d      = o_rms_q;
    o_spk_d      = o_spk_q;
    o_chg_d      = o_chg_q;
    o_tx_d       = o_tx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (job_i.kind == JOB_DROP) begin
            spk_d = 1'b0;
          end else if (job_i.count == '0) begin
            val_d   = '0;
            rem_d   = '0;
            root_d  = '0;
            step_d  = '0;
            state_d = ST_SQRT;
          end else begin
            div_start    = 1'b1;
            div_dividend = job_i.sum;
            div_divisor  = DVSR_W'(job_i.count);
            state_d      = ST_MEAN;
          end
        end
      end
      ST_MEAN: begin
        if (div_done) begin
          // the mean never exceeds one full-scale square
          val_d   = div_quotient[SQRT_IN_W-1:0];
          rem_d   = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        val_d  = {val_q[SQRT_IN_W-3:0], 2'b00};
        rem_d  = sq_fits ? SQRT_REM_W'(sq_shift - sq_trial) : SQRT_REM_W'(sq_shift);
        root_d = {root_q[RMS_W-2:0], sq_fits};
        step_d = step_q + SQRT_CNT_W'(1);
        if (step_q == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
          rms_d   = {root_q[RMS_W-2:0], sq_fits};
          state_d = ST_LSTART;
        end
      end
      ST_LSTART: begin
        div_start = 1'b1;
        state_d   = ST_LEVEL;
      end
      ST_LEVEL: begin
        if (div_done) begin
          lvl_d   = (div_quotient[DIV_W-1:LEVEL_W] != '0) ? '1
                                                          : div_quotient[LEVEL_W-1:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ov_d      = 1'b1;
          o_level_d = lvl_q;
          o_rms_d   = rms_q;
          o_spk_d   = v_spk;
          o_chg_d   = v_spk ^ spk_q;
          o_tx_d    = ~cfg_i.muted;
          spk_d     = v_spk;
          sil_d     = v_sil;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    step_q    <= step_d;
    val_q     <= val_d;
    rem_q     <= rem_d;
    root_q    <= root_d;
    rms_q     <= rms_d;
    lvl_q     <= lvl_d;
    o_level_q <= o_level_d;
    o_rms_q   <= o_rms_d;
    o_spk_q   <= o_spk_d;
    o_chg_q   <= o_chg_d;
    o_tx_q    <= o_tx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      spk_q   <= 1'b0;
      sil_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      spk_q   <= spk_d;
      sil_q   <= sil_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o        = ov_q;
  assign level_o            = o_level_q;
  assign rms_value_o        = o_rms_q;
  assign speaking_o         = o_spk_q;
  assign speaking_changed_o = o_chg_q;
  assign transmit_frame_o   = o_tx_q;

  a_muted_no_onset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free && cfg_i.muted) |-> !(v_spk && !spk_q))
    else $error("speaking entered while muted");
  a_onset_loud: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free && v_spk && !spk_q) |-> (rms_q >= cfg_i.threshold))
    else $error("speaking entered on a quiet frame");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ST_IDLE))
    else $error("job taken while busy");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import frvad_pkg::*;

  localparam int SETTLE_CYCLES = 300;        // covers dropped-sample jobs left after a drain
  localparam int PHASE_ITEMS   = 24;         // sample budget of each enabled random setting phase
  localparam int RANDOM_PHASES = 8;          // one of them runs disabled
  localparam int DISABLED_PHASE = 3;
  localparam int MAX_PRINTED   = 40;

  // one frame result, field for field as the block reports it
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [RMS_W-1:0]   rms;
    logic               speaking;
    logic               changed;
    logic               transmit;
  } vad_result_t;

  // amplitude shapes for generated frames
  typedef enum {
    SHAPE_FLAT,     // every sample at the same magnitude, so rms is exact
    SHAPE_SPREAD,   // magnitudes spread up to a ceiling
    SHAPE_RAW       // any 16-bit pattern
  } shape_e;

  // frame energy predictor plus the queue of frame results still owed by the block
  class vad_frame_scoreboard;
    frvad_cfg_t        cfg;
    logic [SUM_W-1:0]  energy;
    logic [CNT_W-1:0]  count;
    logic              talking;
    logic [HOLD_W-1:0] quiet_run;
    vad_result_t       pending[$];
    int                mismatches;
    int                frames_checked;
    int                samples_taken;
    int                samples_dropped;

    function new();
      cfg.enable     = 1'b0;
      cfg.muted      = 1'b0;
      cfg.threshold  = THRESHOLD_RST;
      cfg.hold       = HOLD_RST;
      cfg.full_scale = FULL_SCALE_RST;
      energy         = '0;
      count          = '0;
      talking        = 1'b0;
      quiet_run      = '0;
    endfunction

    function void set_reg(frvad_reg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ENABLE:     cfg.enable     = val[0];
        REG_MUTED:      cfg.muted      = val[0];
        REG_THRESHOLD:  cfg.threshold  = val[THR_W-1:0];
        REG_HOLD:       cfg.hold       = val[HOLD_W-1:0];
        REG_FULL_SCALE: cfg.full_scale = val[FS_W-1:0];
        default: ;
      endcase
    endfunction

    // bitwise floor square root, msb first
    function logic [RMS_W:0] floor_root(logic [SUM_W-1:0] v);
      logic [RMS_W:0] r;
      logic [RMS_W:0] t;
      r = '0;
      for (int b = RMS_W; b >= 0; b--) begin
        t = r | ((RMS_W+1)'(1) << b);
        if (SUM_W'(t) * SUM_W'(t) <= v) r = t;
      end
      return r;
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s, logic last);
      logic [SAMPLE_W:0] mag;
      logic [SUM_W-1:0]  mean;
      logic [RMS_W:0]    root;
      logic [32:0]       scaled;
      logic [FS_W-1:0]   fs;
      logic              was;
      vad_result_t       r;
      // disabled: sample dropped, partial frame and speaking cleared
      if (!cfg.enable) begin
        energy  = '0;
        count   = '0;
        talking = 1'b0;
        samples_dropped++;
        return;
      end
      samples_taken++;
      mag = s[SAMPLE_W-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
      // past the frame cap, samples are no longer accumulated
      if (count < MAX_FRAME) begin
        energy = energy + SUM_W'(mag) * SUM_W'(mag);
        count++;
      end
      if (!last) return;
      mean   = energy / SUM_W'(count);
      root   = floor_root(mean);
      fs     = (cfg.full_scale == '0) ? FS_W'(1) : cfg.full_scale;
      scaled = (33'(root) * 33'd65535) / 33'(fs);
      r.level = (scaled > 33'd65535) ? 16'hFFFF : scaled[LEVEL_W-1:0];
      r.rms   = root[RMS_W-1:0];
      was = talking;
      if (root >= cfg.threshold) begin
        quiet_run = '0;
        if (!cfg.muted) talking = 1'b1;
      end else if (talking) begin
        quiet_run++;
        if (quiet_run >= cfg.hold) begin
          talking   = 1'b0;
          quiet_run = '0;
        end
      end
      r.speaking = talking;
      r.changed  = (talking != was);
      r.transmit = !cfg.muted;
      pending.push_back(r);
      energy = '0;
      count  = '0;
    endfunction

    task report_mismatch(string what);
      if (mismatches < MAX_PRINTED) $display("mismatch @%0t: %s", $time, what);
      mismatches++;
    endtask

    task check_frame(logic [LEVEL_W-1:0] level, logic [RMS_W-1:0] rms, logic speaking,
                     logic changed, logic transmit);
      vad_result_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result level=%0d rms=%0d", level, rms));
        return;
      end
      want = pending.pop_front();
      frames_checked++;
      if (level !== want.level)
        report_mismatch($sformatf("level got %0d want %0d", level, want.level));
      if (rms !== want.rms)
        report_mismatch($sformatf("rms_value got %0d want %0d", rms, want.rms));
      if (speaking !== want.speaking)
        report_mismatch($sformatf("speaking got %b want %b", speaking, want.speaking));
      if (changed !== want.changed)
        report_mismatch($sformatf("speaking_changed got %b want %b", changed, want.changed));
      if (transmit !== want.transmit)
        report_mismatch($sformatf("transmit_frame got %b want %b", transmit, want.transmit));
    endtask
  endclass

  // clock, reset and every block input known from time zero
  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  logic signed [SAMPLE_W-1:0]  sample_i    = '0;
  logic                        frame_end_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [LEVEL_W-1:0]          level_o;
  logic [RMS_W-1:0]            rms_value_o;
  logic                        speaking_o;
  logic                        speaking_changed_o;
  logic                        transmit_frame_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [CFG_IDX_W-1:0]        cfg_index_i = REG_ENABLE;
  logic [CFG_DATA_W-1:0]       cfg_data_i  = '0;

  vad_frame_scoreboard sb = new();
  int  frame_buf[$];
  bit  no_gaps   = 1'b0;   // sender runs back to back
  bit  no_stalls = 1'b0;   // receiver takes every result at once
  int  stall_left = 0;

  frame_rms_voice_activity_detector_top DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .sample_i           (sample_i),
    .frame_end_i        (frame_end_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .level_o            (level_o),
    .rms_value_o        (rms_value_o),
    .speaking_o         (speaking_o),
    .speaking_changed_o (speaking_changed_o),
    .transmit_frame_o   (transmit_frame_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // result side: each result waits a drawn number of cycles before it is taken;
  // stall stays up between results and counts down only while a result is shown
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      stall_left = no_stalls ? 0 : $urandom_range(0, 6);
    end else if (out_valid_o && stall_left > 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left > 0);
  end

  // every accepted result goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_frame(level_o, rms_value_o, speaking_o, speaking_changed_o, transmit_frame_o);
  end

  // one sample item; valid stays high into the next item when no gap is drawn
  task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_i    <= s;
    frame_end_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(s, last);
  endtask

  // frame_buf holds one whole frame, closing on its last entry
  task automatic send_buf();
    foreach (frame_buf[i]) send_sample(16'(frame_buf[i]), i == frame_buf.size() - 1);
    frame_buf.delete();
  endtask

  function automatic logic signed [SAMPLE_W-1:0] make_sample(shape_e shape, int m);
    int mag;
    case (shape)
      SHAPE_RAW:    return 16'($urandom());
      SHAPE_SPREAD: mag = $urandom_range(0, m);
      default:      mag = m;
    endcase
    if (mag >= 32768) return 16'h8000;
    return ($urandom_range(0, 1) == 1) ? 16'(-mag) : 16'(mag);
  endfunction

  // sender drops valid, then waits for every owed result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // drained plus time for dropped-sample jobs still in the back end
  task automatic finish_phase();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(frvad_reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(logic en, logic mute, logic [15:0] thr, logic [15:0] hold,
                           logic [15:0] fs);
    write_reg(REG_ENABLE, {15'd0, en});
    write_reg(REG_MUTED, {15'd0, mute});
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_HOLD, hold);
    write_reg(REG_FULL_SCALE, fs);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_settings(logic en);
    logic        mute;
    logic [15:0] thr;
    logic [15:0] hold;
    logic [15:0] fs;
    mute = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 5))
      0:       thr = '0;
      1:       thr = 16'($urandom_range(1, 50));
      default: thr = 16'($urandom_range(100, 4000));
    endcase
    case ($urandom_range(0, 5))
      0:       hold = '0;
      1:       hold = 16'd255;
      default: hold = 16'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 4))
      0:       fs = 16'd1;
      1:       fs = 16'hFFFF;
      2:       fs = 16'd32768;
      default: fs = 16'($urandom_range(100, 20000));
    endcase
    configure(en, mute, thr, hold, fs);
  endtask

  // random frames: loud and quiet runs around the threshold so the speaking
  // state enters, holds over and leaves; a few raw frames for bit coverage
  task automatic random_phase(int budget);
    int     sent;
    int     len;
    int     m;
    int     thr;
    int     pick;
    bit     loud;
    shape_e shape;
    sent = 0;
    loud = 1'b0;
    thr  = int'(sb.cfg.threshold);
    while (sent < budget) begin
      no_gaps   = ($urandom_range(0, 4) == 0);
      no_stalls = ($urandom_range(0, 4) == 0);
      // now and then let the back end run dry mid phase
      if ($urandom_range(0, 24) == 0) wait_drained();
      if ($urandom_range(0, 3) == 0) loud = !loud;
      pick = $urandom_range(0, 19);
      if (pick < 10)      len = $urandom_range(1, 4);
      else if (pick < 17) len = $urandom_range(5, 16);
      else                len = $urandom_range(17, 80);
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        // right at the threshold, up to two either side
        shape = SHAPE_FLAT;
        m = thr - 2 + $urandom_range(0, 4);
      end else if (pick < 8) begin
        shape = (pick < 6) ? SHAPE_FLAT : SHAPE_SPREAD;
        if (loud)          m = thr + $urandom_range(0, thr + 100);
        else if (thr == 0) m = 0;
        else               m = $urandom_range(0, thr - 1);
      end else begin
        shape = SHAPE_RAW;
        m = 0;
      end
      if (m < 0) m = 0;
      if (m > 32768) m = 32768;
      for (int i = 0; i < len; i++) send_sample(make_sample(shape, m), i == len - 1);
      sent += len;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, threshold edge, hold-off of two frames
    configure(1'b1, 1'b0, 16'd500, 16'd2, 16'd5000);
    frame_buf = '{0};                   send_buf();  // silent frame
    frame_buf = '{32767};               send_buf();  // max positive, level saturates
    frame_buf = '{-32768};              send_buf();  // max negative, rms 32768
    frame_buf = '{499};                 send_buf();  // quiet while speaking
    frame_buf = '{500};                 send_buf();  // exactly at threshold
    frame_buf = '{499};                 send_buf();
    frame_buf = '{499};                 send_buf();  // hold reached, speaking drops
    frame_buf = '{3, -4};               send_buf();
    frame_buf = '{100, -100, 200, -200}; send_buf();
    frame_buf = '{700, -700};           send_buf();  // back to speaking
    finish_phase();

    // muted: speaking holds, leaves, and cannot come back
    configure(1'b1, 1'b1, 16'd500, 16'd2, 16'd5000);
    frame_buf = '{800};      send_buf();
    frame_buf = '{10};       send_buf();
    frame_buf = '{10};       send_buf();
    frame_buf = '{900};      send_buf();
    frame_buf = '{600, -600}; send_buf();
    finish_phase();

    // zero hold leaves on the first quiet frame, zero full scale acts as one
    configure(1'b1, 1'b0, 16'd1000, 16'd0, 16'd0);
    frame_buf = '{1000}; send_buf();
    frame_buf = '{999};  send_buf();
    frame_buf = '{2000}; send_buf();
    // leave a partial frame open for the disabled phase to discard
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd7, 1'b0);
    finish_phase();

    // disabled: samples dropped, partial frame and speaking state cleared
    configure(1'b0, 1'b0, 16'd1000, 16'd0, 16'd0);
    send_sample(16'sd1234, 1'b0);
    send_sample(-16'sd5, 1'b1);
    send_sample(16'sd77, 1'b1);
    finish_phase();

    // top of the register ranges: nothing counts as voice
    configure(1'b1, 1'b0, 16'hFFFF, 16'd255, 16'hFFFF);
    frame_buf = '{-32768}; send_buf();
    frame_buf = '{1, -1};  send_buf();
    finish_phase();

    // overlong frame: frame cap worth of max negative samples, then
    // random extras that must not be counted, then one quiet frame
    configure(1'b1, 1'b0, 16'd32768, 16'd1, 16'd1);
    for (int i = 0; i < MAX_FRAME; i++) send_sample(16'h8000, 1'b0);
    for (int i = 0; i < 6; i++) send_sample(make_sample(SHAPE_RAW, 0), i == 5);
    frame_buf = '{0}; send_buf();
    finish_phase();

    // random settings, each followed by random frames
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == DISABLED_PHASE) begin
        random_settings(1'b0);
        for (int i = 0; i < 20; i++)
          send_sample(make_sample(SHAPE_RAW, 0), 1'($urandom_range(0, 1)));
      end else begin
        random_settings(1'b1);
        random_phase(PHASE_ITEMS);
      end
      finish_phase();
    end
    no_gaps   = 1'b0;
    no_stalls = 1'b0;

    $display("summary: %0d samples framed, %0d dropped while disabled, %0d frame results checked",
             sb.samples_taken, sb.samples_dropped, sb.frames_checked);
    $display("summary: directed extremes, mute, zero hold/full scale, overlong frame, %0d %s",
             RANDOM_PHASES, "random register settings");
    if (sb.mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
